/* rtl/image_tile_roi_generator_defines.svh */
// assertion macros shared by the tile region generator
`ifndef IMAGE_TILE_ROI_GENERATOR_DEFINES_SVH
`define IMAGE_TILE_ROI_GENERATOR_DEFINES_SVH

// same-cycle implication, idle while in reset
`define ITRG_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("itrg: same-cycle check failed");

// next-cycle implication, idle while in reset
`define ITRG_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("itrg: next-cycle check failed");

`endif

/* rtl/itrg_pkg.sv */
package itrg_pkg;

    // field widths
    localparam int IMG_W       = 15;
    localparam int PAD_W       = 13;
    localparam int DS_W        = 7;
    localparam int TILE_NUM_W  = 6;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 15;

    // divider and pitch widths
    localparam int DIV_NUM_W = 16;
    localparam int DIV_DEN_W = 15;
    localparam int PITCH_W   = 16;

    // register reset values
    localparam logic [IMG_W-1:0] RESET_BUFFER_WIDTH  = 15'd1024;
    localparam logic [IMG_W-1:0] RESET_BUFFER_HEIGHT = 15'd1024;
    localparam logic [PAD_W-1:0] RESET_PAD_PIXELS    = 13'd0;
    localparam logic [DS_W-1:0]  RESET_MAX_DOWNSCALE = 7'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BUFFER_WIDTH,
        REG_BUFFER_HEIGHT,
        REG_PAD_PIXELS,
        REG_MAX_DOWNSCALE
    } itrg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_PAD   = 2'd1,
        STATUS_TILES = 2'd2
    } itrg_status_t;

    // which division the shared divider is working on
    typedef enum logic [1:0] {
        SEL_W_TILES,
        SEL_H_TILES,
        SEL_W_PITCH,
        SEL_H_PITCH
    } itrg_div_sel_t;

    // kind of result loaded into the output register
    typedef enum logic [2:0] {
        PUSH_NONE,
        PUSH_PAD_ERR,
        PUSH_TILE_ERR,
        PUSH_SINGLE,
        PUSH_REGION
    } itrg_push_t;

    typedef struct packed {
        logic [IMG_W-1:0] image_width;
        logic [IMG_W-1:0] image_height;
    } itrg_in_t;

    typedef struct packed {
        logic [IMG_W-1:0]      begin_x;
        logic [IMG_W-1:0]      end_x;
        logic [IMG_W-1:0]      begin_y;
        logic [IMG_W-1:0]      end_y;
        logic [TILE_NUM_W-1:0] tile_number;
        logic [STATUS_W-1:0]   status;
        logic                  last_region;
    } itrg_out_t;

    // controller to datapath
    typedef struct packed {
        logic          capture;
        logic          load_den;
        logic          div_start;
        logic          store_q;
        logic          mul_ds;
        logic          init_scan;
        itrg_div_sel_t sel;
        itrg_push_t    push;
    } itrg_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pad_err;
        logic single;
        logic too_many;
        logic empty;
        logic div_done;
        logic out_free;
        logic last_tile;
    } itrg_sts_t;

endpackage

/* rtl/itrg_if.sv */
// image size channel
interface itrg_image_if;
    logic               valid;
    logic               ready;
    itrg_pkg::itrg_in_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// tile region channel
interface itrg_region_if;
    logic                valid;
    logic                ready;
    itrg_pkg::itrg_out_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* rtl/itrg_div.sv */
`include "image_tile_roi_generator_defines.svh"

// restoring divider, one quotient bit per cycle, rounds the quotient up
module itrg_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [itrg_pkg::IMG_W-1:0]     num,
    input  logic [itrg_pkg::DIV_DEN_W-1:0] den,
    output logic                           done,
    output logic [itrg_pkg::DIV_NUM_W-1:0] quot
);

    localparam int QW = itrg_pkg::DIV_NUM_W;
    localparam int DW = itrg_pkg::DIV_DEN_W;
    localparam int CW = $clog2(QW);
    localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] acc_reg;
    logic [DW-1:0] den_reg;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          fits;
    logic [DW-1:0] rem_next;

    // one trial subtraction
    always_comb
    begin
        trial    = {rem_reg, acc_reg[QW-1]};
        fits     = trial >= {1'b0, den_reg};
        diff     = trial - {1'b0, den_reg};
        rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
    end

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // dividend is biased by den - 1 so the floor becomes a ceiling
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= QW'(num) + QW'(den) - QW'(1);
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[QW-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = acc_reg;

    `ITRG_ASSERT_IMP(a_no_start_busy, clk, rst_n, start, !busy_reg)
    `ITRG_ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg)
    `ITRG_ASSERT_NXT(a_done_after_last, clk, rst_n, busy_reg && !start && cnt_reg == CNT_LAST, done_reg)

endmodule

/* rtl/itrg_dp.sv */
// datapath: registers, tile counts, pitches, region scan and output register
module itrg_dp #(
    parameter int MAX_TILES_PER_SIDE = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [itrg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [itrg_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  itrg_pkg::itrg_in_t               in_payload,
    input  itrg_pkg::itrg_cmd_t              cmd,
    output itrg_pkg::itrg_sts_t              sts,
    output logic                             out_valid,
    input  logic                             out_ready,
    output itrg_pkg::itrg_out_t              out_payload
);

    localparam int IW     = itrg_pkg::IMG_W;
    localparam int PW     = itrg_pkg::PAD_W;
    localparam int DSW    = itrg_pkg::DS_W;
    localparam int NW     = itrg_pkg::DIV_NUM_W;
    localparam int DNW    = itrg_pkg::DIV_DEN_W;
    localparam int PTW    = itrg_pkg::PITCH_W;
    localparam int CNT_W  = $clog2(MAX_TILES_PER_SIDE + 1);
    localparam int IDX_W  = (MAX_TILES_PER_SIDE > 1) ? $clog2(MAX_TILES_PER_SIDE) : 1;
    localparam int ACC_W  = PTW + CNT_W;
    localparam int PROD_W = DSW + CNT_W;
    localparam int PPW    = NW + DSW;

    // configuration registers
    logic [IW-1:0]  bw_reg;
    logic [IW-1:0]  bh_reg;
    logic [PW-1:0]  pad_reg;
    logic [DSW-1:0] ds_reg;

    // per-image working registers
    logic [IW-1:0]  w_reg;
    logic [IW-1:0]  h_reg;
    logic [DNW-1:0] den_reg;
    logic [NW-1:0]  nx_reg;
    logic [NW-1:0]  ny_reg;
    logic [DNW-1:0] dsnx_reg;
    logic [DNW-1:0] dsny_reg;
    logic [PTW-1:0] px_reg;
    logic [PTW-1:0] py_reg;

    // region scan
    logic [ACC_W-1:0]                bx_acc_reg;
    logic [ACC_W-1:0]                ex_acc_reg;
    logic [ACC_W-1:0]                by_acc_reg;
    logic [ACC_W-1:0]                ey_acc_reg;
    logic [IDX_W-1:0]                col_reg;
    logic [IDX_W-1:0]                row_reg;
    logic [itrg_pkg::TILE_NUM_W-1:0] tile_reg;

    // output register
    logic                out_valid_reg;
    logic                out_valid_next;
    itrg_pkg::itrg_out_t out_reg;
    itrg_pkg::itrg_out_t out_next;

    logic [PW:0]      pad2;
    logic [DSW-1:0]   ds_eff;
    logic             pad_err;
    logic             single;
    logic             too_many;
    logic             empty;
    logic             col_last;
    logic             row_last;
    logic             out_free;
    logic [IW-1:0]    div_num;
    logic             div_done;
    logic [NW-1:0]    div_quot;
    logic [PROD_W-1:0] dsnx_prod;
    logic [PROD_W-1:0] dsny_prod;
    logic [PPW-1:0]   pitch_prod;
    logic [IW-1:0]    ex_clamp;
    logic [IW-1:0]    ey_clamp;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg  <= itrg_pkg::RESET_BUFFER_WIDTH;
            bh_reg  <= itrg_pkg::RESET_BUFFER_HEIGHT;
            pad_reg <= itrg_pkg::RESET_PAD_PIXELS;
            ds_reg  <= itrg_pkg::RESET_MAX_DOWNSCALE;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                itrg_pkg::REG_BUFFER_WIDTH:  bw_reg  <= cfg_data[IW-1:0];
                itrg_pkg::REG_BUFFER_HEIGHT: bh_reg  <= cfg_data[IW-1:0];
                itrg_pkg::REG_PAD_PIXELS:    pad_reg <= cfg_data[PW-1:0];
                itrg_pkg::REG_MAX_DOWNSCALE: ds_reg  <= cfg_data[DSW-1:0];
                default:                     ;
            endcase
        end
    end

    // decisions on the captured image size
    always_comb
    begin
        pad2     = {pad_reg, 1'b0};
        ds_eff   = (ds_reg == '0) ? DSW'(1) : ds_reg;
        pad_err  = (IW'(pad2) >= bw_reg) || (IW'(pad2) >= bh_reg);
        single   = (w_reg <= bw_reg) && (h_reg <= bh_reg);
        too_many = (nx_reg > NW'(MAX_TILES_PER_SIDE)) || (ny_reg > NW'(MAX_TILES_PER_SIDE));
        empty    = (nx_reg == '0) || (ny_reg == '0);
        col_last = (NW'(col_reg) + NW'(1)) == nx_reg;
        row_last = (NW'(row_reg) + NW'(1)) == ny_reg;
        out_free = !out_valid_reg || out_ready;
        div_num  = (cmd.sel == itrg_pkg::SEL_W_TILES || cmd.sel == itrg_pkg::SEL_W_PITCH)
                   ? w_reg : h_reg;
    end

    // small products: downscale times tile count, quotient times downscale
    assign dsnx_prod  = PROD_W'(ds_eff) * PROD_W'(nx_reg[CNT_W-1:0]);
    assign dsny_prod  = PROD_W'(ds_eff) * PROD_W'(ny_reg[CNT_W-1:0]);
    assign pitch_prod = PPW'(div_quot) * PPW'(ds_eff);

    itrg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // tile counts, divisors and pitches
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            w_reg <= in_payload.image_width;
            h_reg <= in_payload.image_height;
        end
        if (cmd.load_den)
        begin
            case (cmd.sel)
                itrg_pkg::SEL_W_TILES: den_reg <= bw_reg - IW'(pad2);
                itrg_pkg::SEL_H_TILES: den_reg <= bh_reg - IW'(pad2);
                itrg_pkg::SEL_W_PITCH: den_reg <= dsnx_reg;
                default:               den_reg <= dsny_reg;
            endcase
        end
        if (cmd.store_q)
        begin
            case (cmd.sel)
                itrg_pkg::SEL_W_TILES: nx_reg <= div_quot;
                itrg_pkg::SEL_H_TILES: ny_reg <= div_quot;
                itrg_pkg::SEL_W_PITCH: px_reg <= pitch_prod[PTW-1:0];
                default:               py_reg <= pitch_prod[PTW-1:0];
            endcase
        end
        if (cmd.mul_ds)
        begin
            dsnx_reg <= DNW'(dsnx_prod);
            dsny_reg <= DNW'(dsny_prod);
        end
    end

    // column-major scan, ends kept as running sums including the padding
    always_ff @(posedge clk)
    begin
        if (cmd.init_scan)
        begin
            bx_acc_reg <= '0;
            ex_acc_reg <= ACC_W'(px_reg) + ACC_W'(pad_reg);
            by_acc_reg <= '0;
            ey_acc_reg <= ACC_W'(py_reg) + ACC_W'(pad_reg);
            col_reg    <= '0;
            row_reg    <= '0;
            tile_reg   <= '0;
        end
        else if (cmd.push == itrg_pkg::PUSH_REGION)
        begin
            tile_reg <= tile_reg + itrg_pkg::TILE_NUM_W'(1);
            if (row_last)
            begin
                row_reg    <= '0;
                by_acc_reg <= '0;
                ey_acc_reg <= ACC_W'(py_reg) + ACC_W'(pad_reg);
                col_reg    <= col_reg + IDX_W'(1);
                bx_acc_reg <= bx_acc_reg + ACC_W'(px_reg);
                ex_acc_reg <= ex_acc_reg + ACC_W'(px_reg);
            end
            else
            begin
                row_reg    <= row_reg + IDX_W'(1);
                by_acc_reg <= by_acc_reg + ACC_W'(py_reg);
                ey_acc_reg <= ey_acc_reg + ACC_W'(py_reg);
            end
        end
    end

    // region ends clamped to the image edge
    assign ex_clamp = (ex_acc_reg > ACC_W'(w_reg)) ? w_reg : ex_acc_reg[IW-1:0];
    assign ey_clamp = (ey_acc_reg > ACC_W'(h_reg)) ? h_reg : ey_acc_reg[IW-1:0];

    // output register load
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (cmd.push)
            itrg_pkg::PUSH_PAD_ERR:
            begin
                out_next        = '0;
                out_next.status = itrg_pkg::STATUS_PAD;
                out_next.last_region = 1'b1;
                out_valid_next  = 1'b1;
            end
            itrg_pkg::PUSH_TILE_ERR:
            begin
                out_next        = '0;
                out_next.status = itrg_pkg::STATUS_TILES;
                out_next.last_region = 1'b1;
                out_valid_next  = 1'b1;
            end
            itrg_pkg::PUSH_SINGLE:
            begin
                out_next             = '0;
                out_next.end_x       = w_reg;
                out_next.end_y       = h_reg;
                out_next.status      = itrg_pkg::STATUS_OK;
                out_next.last_region = 1'b1;
                out_valid_next       = 1'b1;
            end
            itrg_pkg::PUSH_REGION:
            begin
                out_next.begin_x     = bx_acc_reg[IW-1:0];
                out_next.end_x       = ex_clamp;
                out_next.begin_y     = by_acc_reg[IW-1:0];
                out_next.end_y       = ey_clamp;
                out_next.tile_number = tile_reg;
                out_next.status      = itrg_pkg::STATUS_OK;
                out_next.last_region = col_last && row_last;
                out_valid_next       = 1'b1;
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_payload = out_reg;

    // status to the controller
    always_comb
    begin
        sts.pad_err   = pad_err;
        sts.single    = single;
        sts.too_many  = too_many;
        sts.empty     = empty;
        sts.div_done  = div_done;
        sts.out_free  = out_free;
        sts.last_tile = col_last && row_last;
    end

endmodule

/* rtl/itrg_ctrl.sv */
`include "image_tile_roi_generator_defines.svh"

// controller: sequences the checks, the four divisions and the region scan
module itrg_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  itrg_pkg::itrg_sts_t sts,
    output itrg_pkg::itrg_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_LOAD,
        S_START,
        S_WAIT,
        S_COUNT_CHECK,
        S_MUL,
        S_INIT,
        S_EMIT,
        S_EMIT_PAD,
        S_EMIT_TILES,
        S_EMIT_SINGLE
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    itrg_pkg::itrg_div_sel_t sel_reg;
    itrg_pkg::itrg_div_sel_t sel_next;

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.sel       = sel_reg;
        cmd.push      = itrg_pkg::PUSH_NONE;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.pad_err)
                begin
                    state_next = S_EMIT_PAD;
                end
                else if (sts.single)
                begin
                    state_next = S_EMIT_SINGLE;
                end
                else
                begin
                    sel_next   = itrg_pkg::SEL_W_TILES;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load_den = 1'b1;
                state_next   = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.store_q = 1'b1;
                    case (sel_reg)
                        itrg_pkg::SEL_W_TILES:
                        begin
                            sel_next   = itrg_pkg::SEL_H_TILES;
                            state_next = S_LOAD;
                        end
                        itrg_pkg::SEL_H_TILES:
                        begin
                            state_next = S_COUNT_CHECK;
                        end
                        itrg_pkg::SEL_W_PITCH:
                        begin
                            sel_next   = itrg_pkg::SEL_H_PITCH;
                            state_next = S_LOAD;
                        end
                        default:
                        begin
                            state_next = S_INIT;
                        end
                    endcase
                end
            end
            S_COUNT_CHECK:
            begin
                if (sts.too_many)
                begin
                    state_next = S_EMIT_TILES;
                end
                else if (sts.empty)
                begin
                    // a zero side gives no regions at all
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_ds = 1'b1;
                sel_next   = itrg_pkg::SEL_W_PITCH;
                state_next = S_LOAD;
            end
            S_INIT:
            begin
                cmd.init_scan = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.push = itrg_pkg::PUSH_REGION;
                    if (sts.last_tile)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMIT_PAD:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = itrg_pkg::PUSH_PAD_ERR;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_TILES:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = itrg_pkg::PUSH_TILE_ERR;
                    state_next = S_IDLE;
                end
            end
            S_EMIT_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = itrg_pkg::PUSH_SINGLE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and division select
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= itrg_pkg::SEL_W_TILES;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    `ITRG_ASSERT_IMP(a_push_when_free, clk, rst_n, cmd.push != itrg_pkg::PUSH_NONE, sts.out_free)
    `ITRG_ASSERT_NXT(a_last_region_idle, clk, rst_n, cmd.push == itrg_pkg::PUSH_REGION && sts.last_tile, state_reg == S_IDLE)
    `ITRG_ASSERT_IMP(a_scan_counts_ok, clk, rst_n, cmd.init_scan, !sts.too_many && !sts.empty)

endmodule

/* rtl/image_tile_roi_generator.sv */
// Tile region generator: one image size in, the list of tile regions out.
// image  : valid/ready channel carrying image_width and image_height; one
//          transaction per image, taken only while the block is idle.
// region : valid/ready channel carrying one region per transaction, column-major,
//          last_region marks the final one; errors give a single transaction
//          with status set and zero bounds.
// cfg    : write port (cfg_write, cfg_index, cfg_data) for the four registers,
//          to be written only between images.
// A padding error or a whole-image region is chosen in the check state after the
// image transaction. A tiled image runs four 16-step divisions on one shared
// divider plus control steps: the two tile counts, a tile-count check that may
// give the error, then the two pitches and the region scan; regions follow one
// per cycle while the receiver takes them. An image with a zero side gives no
// region and the block goes back to idle after the tile-count check.
// The output register lets a new image be taken while the last region waits.
// A receiver stall holds the region in the output register and pauses the
// scan; nothing is lost. Reset returns the registers to their defaults and
// the controller to idle with no region pending.
module image_tile_roi_generator #(
    parameter int MAX_TILES_PER_SIDE = 8
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    itrg_image_if.sink                       image,
    itrg_region_if.source                    region,
    input  logic                             cfg_write,
    input  logic [itrg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [itrg_pkg::CFG_DATA_W-1:0]  cfg_data
);

    itrg_pkg::itrg_cmd_t cmd;
    itrg_pkg::itrg_sts_t sts;
    logic                in_ready;
    logic                out_valid;
    itrg_pkg::itrg_out_t out_payload;

    itrg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (image.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    itrg_dp #(
        .MAX_TILES_PER_SIDE (MAX_TILES_PER_SIDE)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_payload  (image.payload),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (region.ready),
        .out_payload (out_payload)
    );

    // channel hookup
    assign image.ready    = in_ready;
    assign region.valid   = out_valid;
    assign region.payload = out_payload;

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int          MAX_TILES     = 8;
    localparam int          SETTLE_CYCLES = 120;
    localparam int unsigned CYCLE_LIMIT   = 3000000;
    localparam int unsigned IMG_MAX       = 32767;
    localparam int          N_DIRECTED    = 23;
    localparam int          IMG_W         = itrg_pkg::IMG_W;
    localparam int          TILE_NUM_W    = itrg_pkg::TILE_NUM_W;
    localparam int          CFG_INDEX_W   = itrg_pkg::CFG_INDEX_W;
    localparam int          CFG_DATA_W    = itrg_pkg::CFG_DATA_W;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    itrg_image_if  image_ch ();
    itrg_region_if region_ch ();

    image_tile_roi_generator #(
        .MAX_TILES_PER_SIDE (MAX_TILES)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .image     (image_ch),
        .region    (region_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the registers
    int unsigned buf_w;
    int unsigned buf_h;
    int unsigned pad_px;
    int unsigned downscale;

    itrg_pkg::itrg_out_t expected_regions [$];
    int unsigned         sender_gap_pct;
    int unsigned         receiver_stall_pct;
    int                  mismatches  = 0;
    int unsigned         cycle_count = 0;

    // directed rows: configuration, image size, and a typed single result where obvious
    typedef struct {
        int                     bw;
        int                     bh;
        int                     pad;
        int                     ds;
        int                     w;
        int                     h;
        bit                     fixed;
        int                     exp_ex;
        int                     exp_ey;
        itrg_pkg::itrg_status_t exp_st;
    } directed_row_t;

    directed_row_t directed [N_DIRECTED] = '{
        // defaults after reset
        '{1024, 1024, 0, 1, 1, 1, 1'b1, 1, 1, itrg_pkg::STATUS_OK},
        '{1024, 1024, 0, 1, 1024, 1024, 1'b1, 1024, 1024, itrg_pkg::STATUS_OK},
        '{1024, 1024, 0, 1, 0, 0, 1'b1, 0, 0, itrg_pkg::STATUS_OK},
        '{1024, 1024, 0, 1, 1025, 1, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        '{1024, 1024, 0, 1, 8192, 8192, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        '{1024, 1024, 0, 1, 8193, 1, 1'b1, 0, 0, itrg_pkg::STATUS_TILES},
        '{1024, 1024, 0, 1, 32767, 32767, 1'b1, 0, 0, itrg_pkg::STATUS_TILES},
        // zero width on a tall image gives no region at all
        '{1024, 1024, 0, 1, 0, 2000, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        // padded tiles with pitch aligned to the downscale
        '{100, 60, 10, 8, 500, 200, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        '{100, 60, 10, 8, 101, 30, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        '{100, 60, 10, 8, 100, 60, 1'b1, 100, 60, itrg_pkg::STATUS_OK},
        // padding fills the buffer
        '{50, 1024, 25, 1, 1, 1, 1'b1, 0, 0, itrg_pkg::STATUS_PAD},
        '{50, 1024, 25, 1, 32767, 32767, 1'b1, 0, 0, itrg_pkg::STATUS_PAD},
        '{1024, 10, 5, 1, 2000, 5, 1'b1, 0, 0, itrg_pkg::STATUS_PAD},
        // largest padding that still fits
        '{16384, 16384, 8191, 64, 16384, 16384, 1'b1, 16384, 16384, itrg_pkg::STATUS_OK},
        '{16384, 16384, 8191, 64, 16385, 1, 1'b1, 0, 0, itrg_pkg::STATUS_TILES},
        // zero downscale behaves as one
        '{32767, 32767, 0, 0, 32767, 32767, 1'b1, 32767, 32767, itrg_pkg::STATUS_OK},
        // pitch overshoots the image edge
        '{1, 1, 0, 127, 7, 7, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        '{1, 1, 0, 127, 8, 9, 1'b1, 0, 0, itrg_pkg::STATUS_TILES},
        '{1, 1, 0, 127, 1, 2, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        // zero buffer width
        '{0, 100, 0, 1, 5, 5, 1'b1, 0, 0, itrg_pkg::STATUS_PAD},
        '{3000, 2000, 100, 64, 20000, 12000, 1'b0, 0, 0, itrg_pkg::STATUS_OK},
        '{8192, 4096, 8191, 127, 1, 1, 1'b1, 0, 0, itrg_pkg::STATUS_PAD}
    };

    always #5 clk = ~clk;

    function automatic int unsigned ceil_div(input int unsigned a, input int unsigned b);
        if (b == 0)
        begin
            return 0;
        end
        return (a + b - 1) / b;
    endfunction

    // regions an image is split into under the current registers
    function automatic void tile_image(input itrg_pkg::itrg_in_t img,
                                       ref itrg_pkg::itrg_out_t regions [$]);
        int unsigned         w;
        int unsigned         h;
        int unsigned         ds;
        int unsigned         pad2;
        int unsigned         nx;
        int unsigned         ny;
        int unsigned         px;
        int unsigned         py;
        int unsigned         bx;
        int unsigned         ex;
        int unsigned         by;
        int unsigned         ey;
        int unsigned         num;
        int unsigned         i;
        int unsigned         j;
        itrg_pkg::itrg_out_t r;

        w    = img.image_width;
        h    = img.image_height;
        ds   = (downscale == 0) ? 1 : downscale;
        pad2 = 2 * pad_px;
        r    = '0;
        r.last_region = 1'b1;

        // padding leaves no room for a tile body
        if (pad2 >= buf_w || pad2 >= buf_h)
        begin
            r.status = itrg_pkg::STATUS_PAD;
            regions.push_back(r);
            return;
        end

        // whole image fits one buffer
        if (w <= buf_w && h <= buf_h)
        begin
            r.end_x  = IMG_W'(w);
            r.end_y  = IMG_W'(h);
            r.status = itrg_pkg::STATUS_OK;
            regions.push_back(r);
            return;
        end

        nx = ceil_div(w, buf_w - pad2);
        ny = ceil_div(h, buf_h - pad2);
        if (nx > MAX_TILES || ny > MAX_TILES)
        begin
            r.status = itrg_pkg::STATUS_TILES;
            regions.push_back(r);
            return;
        end

        px = ceil_div(ceil_div(w, ds), nx) * ds;
        py = ceil_div(ceil_div(h, ds), ny) * ds;

        // column-major scan, ends padded and clamped to the image
        num = 0;
        for (i = 0; i < nx; i++)
        begin
            bx = i * px;
            ex = (i + 1) * px + pad_px;
            if (ex > w)
            begin
                ex = w;
            end
            for (j = 0; j < ny; j++)
            begin
                by = j * py;
                ey = (j + 1) * py + pad_px;
                if (ey > h)
                begin
                    ey = h;
                end
                r.begin_x     = IMG_W'(bx);
                r.end_x       = IMG_W'(ex);
                r.begin_y     = IMG_W'(by);
                r.end_y       = IMG_W'(ey);
                r.tile_number = TILE_NUM_W'(num);
                r.status      = itrg_pkg::STATUS_OK;
                r.last_region = (i + 1 == nx && j + 1 == ny);
                regions.push_back(r);
                num++;
            end
        end
    endfunction

    // one image transaction, with a random gap in front
    task automatic send_image(input itrg_pkg::itrg_in_t img);
        if (sender_gap_pct != 0 && $urandom_range(99) < sender_gap_pct)
        begin
            image_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_gap_pct);
        end
        image_ch.valid   <= 1'b1;
        image_ch.payload <= img;
        @(posedge clk);
        while (!image_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // hold off until every region is in, then let the divider settle
    task automatic wait_for_drain();
        image_ch.valid <= 1'b0;
        while (expected_regions.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input itrg_pkg::itrg_reg_t idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        case (idx)
            itrg_pkg::REG_BUFFER_WIDTH:  buf_w     = value & 32'h7fff;
            itrg_pkg::REG_BUFFER_HEIGHT: buf_h     = value & 32'h7fff;
            itrg_pkg::REG_PAD_PIXELS:    pad_px    = value & 32'h1fff;
            itrg_pkg::REG_MAX_DOWNSCALE: downscale = value & 32'h7f;
            default: ;
        endcase
    endtask

    task automatic load_config(input int unsigned bw, input int unsigned bh,
                               input int unsigned pad, input int unsigned ds);
        wait_for_drain();
        write_reg(itrg_pkg::REG_BUFFER_WIDTH, bw);
        write_reg(itrg_pkg::REG_BUFFER_HEIGHT, bh);
        write_reg(itrg_pkg::REG_PAD_PIXELS, pad);
        write_reg(itrg_pkg::REG_MAX_DOWNSCALE, ds);
        cfg_write <= 1'b0;
    endtask

    function automatic int unsigned pick_buffer();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(3))
                    0:       return 0;
                    1:       return 1;
                    2:       return 16384;
                    default: return 32767;
                endcase
            end
            1:       return $urandom_range(IMG_MAX, 0);
            default: return $urandom_range(3000, 4);
        endcase
    endfunction

    task automatic load_random_config();
        int unsigned bw;
        int unsigned bh;
        int unsigned pad;
        int unsigned ds;

        bw = pick_buffer();
        bh = pick_buffer();
        if ($urandom_range(99) < 85)
        begin
            pad = $urandom_range(((bw < bh) ? bw : bh) / 6, 0);
        end
        else
        begin
            pad = $urandom_range(8191, 0);
        end
        if ($urandom_range(99) < 80)
        begin
            ds = $urandom_range(64, 1);
        end
        else
        begin
            ds = $urandom_range(127, 0);
        end
        load_config(bw, bh, pad, ds);
    endtask

    // side length giving between one and one-too-many tiles of body size span
    function automatic int unsigned pick_side(input int unsigned span);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;

        n  = $urandom_range(MAX_TILES + 1, 1);
        lo = (n - 1) * span + 1;
        hi = n * span;
        if (hi > IMG_MAX)
        begin
            hi = IMG_MAX;
        end
        if (lo > hi)
        begin
            lo = hi;
        end
        if ($urandom_range(3) == 0)
        begin
            return hi;
        end
        return $urandom_range(hi, lo);
    endfunction

    // mostly sizes that tile within bounds, the rest anything the fields hold
    function automatic itrg_pkg::itrg_in_t random_image();
        itrg_pkg::itrg_in_t img;

        if ($urandom_range(99) < 75 && buf_w > 2 * pad_px && buf_h > 2 * pad_px)
        begin
            img.image_width  = IMG_W'(pick_side(buf_w - 2 * pad_px));
            img.image_height = IMG_W'(pick_side(buf_h - 2 * pad_px));
        end
        else
        begin
            img.image_width  = IMG_W'($urandom_range(IMG_MAX, 0));
            img.image_height = IMG_W'($urandom_range(IMG_MAX, 0));
        end
        return img;
    endfunction

    // receiver back-pressure
    initial
    begin
        region_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            region_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // compare each region transaction with the oldest expectation
    always @(posedge clk)
    begin : region_check
        itrg_pkg::itrg_out_t want;
        itrg_pkg::itrg_out_t got;

        if (rst_n && region_ch.valid === 1'b1 && region_ch.ready)
        begin
            got = region_ch.payload;
            if (expected_regions.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected region: x %0d..%0d y %0d..%0d n %0d st %0d last %0d",
                             got.begin_x, got.end_x, got.begin_y, got.end_y,
                             got.tile_number, got.status, got.last_region);
                end
            end
            else
            begin
                want = expected_regions.pop_front();
                if (got.begin_x !== want.begin_x || got.end_x !== want.end_x ||
                    got.begin_y !== want.begin_y || got.end_y !== want.end_y ||
                    got.tile_number !== want.tile_number || got.status !== want.status ||
                    got.last_region !== want.last_region)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("region mismatch: exp x %0d..%0d y %0d..%0d n %0d st %0d last %0d",
                                 want.begin_x, want.end_x, want.begin_y, want.end_y,
                                 want.tile_number, want.status, want.last_region);
                        $display("                 got x %0d..%0d y %0d..%0d n %0d st %0d last %0d",
                                 got.begin_x, got.end_x, got.begin_y, got.end_y,
                                 got.tile_number, got.status, got.last_region);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        itrg_pkg::itrg_in_t  img;
        itrg_pkg::itrg_out_t fixed_res;
        int                  row;
        int                  phase;
        int                  cfg_n;
        int                  item;

        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        image_ch.valid     = 1'b0;
        image_ch.payload   = '0;
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        buf_w              = itrg_pkg::RESET_BUFFER_WIDTH;
        buf_h              = itrg_pkg::RESET_BUFFER_HEIGHT;
        pad_px             = itrg_pkg::RESET_PAD_PIXELS;
        downscale          = itrg_pkg::RESET_MAX_DOWNSCALE;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (row = 0; row < N_DIRECTED; row++)
        begin
            if (row == 0 || directed[row].bw != buf_w || directed[row].bh != buf_h ||
                directed[row].pad != pad_px || directed[row].ds != downscale)
            begin
                load_config(directed[row].bw, directed[row].bh, directed[row].pad,
                            directed[row].ds);
            end
            img.image_width  = IMG_W'(directed[row].w);
            img.image_height = IMG_W'(directed[row].h);
            send_image(img);
            if (directed[row].fixed)
            begin
                fixed_res             = '0;
                fixed_res.end_x       = IMG_W'(directed[row].exp_ex);
                fixed_res.end_y       = IMG_W'(directed[row].exp_ey);
                fixed_res.status      = directed[row].exp_st;
                fixed_res.last_region = 1'b1;
                expected_regions.push_back(fixed_res);
            end
            else
            begin
                tile_image(img, expected_regions);
            end
        end

        // random phases with different idling on each side
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_gap_pct     = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_gap_pct     = 71;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_gap_pct     = 0;
                    receiver_stall_pct = 71;
                end
                default:
                begin
                    sender_gap_pct     = 26;
                    receiver_stall_pct = 26;
                end
            endcase
            for (cfg_n = 0; cfg_n < 3; cfg_n++)
            begin
                load_random_config();
                for (item = 0; item < 30; item++)
                begin
                    img = random_image();
                    send_image(img);
                    tile_image(img, expected_regions);
                    if ($urandom_range(99) < 3)
                    begin
                        wait_for_drain();
                    end
                end
            end
        end

        wait_for_drain();
        if (mismatches == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/itrg_pkg.sv
rtl/itrg_if.sv
rtl/itrg_div.sv
rtl/itrg_dp.sv
rtl/itrg_ctrl.sv
rtl/image_tile_roi_generator.sv
tb/tb.sv
